[rtl/core/tmbc_pkg.sv]
package tmbc_pkg;

  // Default sizing
  localparam int MAX_TILES_DEF = 4096;
  localparam int FRAC_BITS_DEF = 4;

  // Field widths
  localparam int POS_W   = 20;
  localparam int SIZE_W  = 16;
  localparam int INDEX_W = 12;
  localparam int TS_W    = 9;
  localparam int MAP_W   = 7;
  localparam int CAUSE_W = 2;

  // Result cause codes
  localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_OUTSIDE = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_SOLID   = 2'd2;

  // Input op codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register map (index = paddr[3:2])
  localparam logic [1:0] REG_TILE_SIZE  = 2'd0;
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd1;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd2;

  localparam logic [TS_W-1:0]  TILE_SIZE_RST  = 9'd16;
  localparam logic [MAP_W-1:0] MAP_WIDTH_RST  = 7'd64;
  localparam logic [MAP_W-1:0] MAP_HEIGHT_RST = 7'd64;

endpackage

[rtl/core/tmbc_req_if.sv]
interface tmbc_req_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [tmbc_pkg::INDEX_W-1:0]        tile_index;
  logic                                tile_solid;
  logic signed [tmbc_pkg::POS_W-1:0]   pos_x;
  logic signed [tmbc_pkg::POS_W-1:0]   pos_y;
  logic [tmbc_pkg::SIZE_W-1:0]         box_w;
  logic [tmbc_pkg::SIZE_W-1:0]         box_h;

  modport source (output valid, op, tile_index, tile_solid, pos_x, pos_y, box_w, box_h,
                  input ready);
  modport sink   (input valid, op, tile_index, tile_solid, pos_x, pos_y, box_w, box_h,
                  output ready);
endinterface

[rtl/core/tmbc_rsp_if.sv]
interface tmbc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           collides;
  logic [tmbc_pkg::CAUSE_W-1:0]   cause;

  modport source (output valid, collides, cause, input ready);
  modport sink   (input valid, collides, cause, output ready);
endinterface

[rtl/core/tmbc_ram.sv]
module tmbc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/tile_map_box_collision.sv]
// Box-against-tile-map collision. Op 0 writes one tile's solid bit and returns
// nothing; op 1 checks a fixed-point box and returns one transaction with
// collides and cause. A query holds the input through accept, outside check
// and result when the box leaves the map. Otherwise it also runs four
// divisions by the tile size on one shared bit-serial divider, then scans
// tiles. Tiles are scanned from the solid map up to the first solid one.
// After reset the solid map is cleared one entry per cycle before the first
// input is taken; registers can be written during that pass.
module tile_map_box_collision #(
  parameter int MAX_TILES = tmbc_pkg::MAX_TILES_DEF,
  parameter int FRAC_BITS = tmbc_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tmbc_req_if.sink    req,
  tmbc_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW  = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CW  = AW + 1;
  localparam int PXW = tmbc_pkg::POS_W + 1;  // edge sums and magnitudes
  localparam int DW  = 15;                   // divider dividend bits
  localparam int QW  = 7;                    // tile coordinate bits
  localparam int IXW = 13;                   // linear tile index bits

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_SCANW = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;

  // Configuration registers
  logic [tmbc_pkg::TS_W-1:0]  tile_size;
  logic [tmbc_pkg::MAP_W-1:0] map_width;
  logic [tmbc_pkg::MAP_W-1:0] map_height;
  logic                       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size  <= tmbc_pkg::TILE_SIZE_RST;
      map_width  <= tmbc_pkg::MAP_WIDTH_RST;
      map_height <= tmbc_pkg::MAP_HEIGHT_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        tmbc_pkg::REG_TILE_SIZE:  tile_size  <= pwdata[tmbc_pkg::TS_W-1:0];
        tmbc_pkg::REG_MAP_WIDTH:  map_width  <= pwdata[tmbc_pkg::MAP_W-1:0];
        tmbc_pkg::REG_MAP_HEIGHT: map_height <= pwdata[tmbc_pkg::MAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tmbc_pkg::REG_TILE_SIZE:  prdata = 32'(tile_size);
      tmbc_pkg::REG_MAP_WIDTH:  prdata = 32'(map_width);
      tmbc_pkg::REG_MAP_HEIGHT: prdata = 32'(map_height);
      default:                  prdata = 32'd0;
    endcase
  end

  // Clamped register values and map extent in pixels
  logic [8:0]    ts_c;
  logic [6:0]    mw_c;
  logic [6:0]    mh_c;
  logic [DW-1:0] map_px_w;
  logic [DW-1:0] map_px_h;

  always_comb begin
    ts_c = (tile_size == '0) ? 9'd1 : ((tile_size > 9'd256) ? 9'd256 : tile_size);
    mw_c = (map_width == '0) ? 7'd1 : ((map_width > 7'd64) ? 7'd64 : map_width);
    mh_c = (map_height == '0) ? 7'd1 : ((map_height > 7'd64) ? 7'd64 : map_height);
  end

  always_ff @(posedge clk) begin
    map_px_w <= DW'(ts_c) * DW'(mw_c);
    map_px_h <= DW'(ts_c) * DW'(mh_c);
  end

  // Captured box edges (fixed point)
  logic signed [PXW-1:0] ex_l, ex_t, ex_r, ex_b;

  // Truncate toward zero: magnitude of whole pixels
  logic [PXW-1:0] mag_l, mag_t, mag_r, mag_b;
  logic [PXW-1:0] pix_l, pix_t, pix_r, pix_b;
  logic           outside;

  always_comb begin
    mag_l = ex_l[PXW-1] ? PXW'(-ex_l) : PXW'(ex_l);
    mag_t = ex_t[PXW-1] ? PXW'(-ex_t) : PXW'(ex_t);
    mag_r = ex_r[PXW-1] ? PXW'(-ex_r) : PXW'(ex_r);
    mag_b = ex_b[PXW-1] ? PXW'(-ex_b) : PXW'(ex_b);
    pix_l = mag_l >> FRAC_BITS;
    pix_t = mag_t >> FRAC_BITS;
    pix_r = mag_r >> FRAC_BITS;
    pix_b = mag_b >> FRAC_BITS;
    outside = (ex_l[PXW-1] && pix_l != '0) || (ex_t[PXW-1] && pix_t != '0) ||
              (!ex_r[PXW-1] && pix_r > PXW'(map_px_w)) ||
              (!ex_b[PXW-1] && pix_b > PXW'(map_px_h));
  end

  // Shared divider: restoring, one quotient bit per cycle
  logic [DW-1:0]  dvd [4];
  logic [1:0]     div_k;
  logic [3:0]     div_cnt;
  logic [DW-1:0]  div_sh;
  logic [8:0]     div_rem;
  logic [DW-1:0]  div_q;
  logic [9:0]     div_cat;
  logic [10:0]    div_trial;
  logic           div_bit;
  logic [8:0]     div_rem_next;
  logic [DW-1:0]  div_q_next;
  logic [QW-1:0]  quo [4];   // left col, top row, right col end, bottom row end

  always_comb begin
    div_cat      = {div_rem, div_sh[DW-1]};
    div_trial    = {1'b0, div_cat} - {2'b0, ts_c};
    div_bit      = !div_trial[10];
    div_rem_next = div_bit ? div_trial[8:0] : div_cat[8:0];
    div_q_next   = {div_q[DW-2:0], div_bit};
  end

  // Scan state
  logic [QW-1:0]  col;
  logic [QW-1:0]  row;
  logic [IXW-1:0] row_base;
  logic [IXW-1:0] scan_idx;
  logic           rd_ok;
  logic           ram_rdata;

  assign scan_idx = row_base + IXW'(col);

  // Solid map write port: clearing pass or tile writes
  logic [CW-1:0] clr_cnt;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          req_fire;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt[AW-1:0];
      ram_wdata = 1'b0;
    end else begin
      ram_we    = req_fire && req.op == tmbc_pkg::OP_WRITE &&
                  32'(req.tile_index) < 32'(MAX_TILES);
      ram_waddr = AW'(req.tile_index);
      ram_wdata = req.tile_solid;
    end
  end

  tmbc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_TILES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(scan_idx)),
    .rdata (ram_rdata)
  );

  // Result register
  logic                          rsp_valid;
  logic [tmbc_pkg::CAUSE_W-1:0]  rsp_cause;
  logic [tmbc_pkg::CAUSE_W-1:0]  cause;

  assign rsp.valid    = rsp_valid;
  assign rsp.cause    = rsp_cause;
  assign rsp.collides = (rsp_cause != tmbc_pkg::CAUSE_NONE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Result valid: set when a result is loaded, cleared when taken
      if (state == S_DONE && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CW'(MAX_TILES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire && req.op == tmbc_pkg::OP_QUERY) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (outside) begin
            state <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == 4'(DW - 1) && div_k == 2'd3) begin
            if (quo[1] >= div_q_next[QW-1:0] || quo[0] >= quo[2]) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          state <= S_SCANW;
        end
        S_SCANW: begin
          if (rd_ok && ram_rdata) begin
            state <= S_DONE;
          end else if (col + 1'b1 == quo[2] && row + 1'b1 == quo[3]) begin
            state <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ex_l  <= PXW'(req.pos_x);
        ex_t  <= PXW'(req.pos_y);
        ex_r  <= PXW'(req.pos_x) + $signed(PXW'(req.box_w));
        ex_b  <= PXW'(req.pos_y) + $signed(PXW'(req.box_h));
        cause <= tmbc_pkg::CAUSE_NONE;
      end
      S_CHECK: begin
        cause   <= outside ? tmbc_pkg::CAUSE_OUTSIDE : tmbc_pkg::CAUSE_NONE;
        dvd[0]  <= DW'(pix_l);
        dvd[1]  <= DW'(pix_t);
        dvd[2]  <= DW'(pix_r + PXW'(ts_c) - 1'b1);
        dvd[3]  <= DW'(pix_b + PXW'(ts_c) - 1'b1);
        div_k   <= 2'd0;
        div_cnt <= 4'd0;
        div_sh  <= DW'(pix_l);
        div_rem <= '0;
        div_q   <= '0;
      end
      S_DIV: begin
        if (div_cnt == 4'(DW - 1)) begin
          quo[div_k] <= div_q_next[QW-1:0];
          div_k      <= div_k + 1'b1;
          div_cnt    <= 4'd0;
          div_sh     <= dvd[div_k + 1'b1];
          div_rem    <= '0;
          div_q      <= '0;
          if (div_k == 2'd3) begin
            col      <= quo[0];
            row      <= quo[1];
            row_base <= IXW'(quo[1]) * IXW'(mw_c);
          end
        end else begin
          div_cnt <= div_cnt + 1'b1;
          div_sh  <= {div_sh[DW-2:0], 1'b0};
          div_rem <= div_rem_next;
          div_q   <= div_q_next;
        end
      end
      S_SCAN: begin
        rd_ok <= 32'(scan_idx) < 32'(MAX_TILES);
      end
      S_SCANW: begin
        if (rd_ok && ram_rdata) begin
          cause <= tmbc_pkg::CAUSE_SOLID;
        end else if (col + 1'b1 == quo[2]) begin
          col      <= quo[0];
          row      <= row + 1'b1;
          row_base <= row_base + IXW'(mw_c);
        end else begin
          col <= col + 1'b1;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_cause <= cause;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/tmbc_chk.sv]
module tmbc_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          req_op,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          rsp_collides,
  input logic [tmbc_pkg::CAUSE_W-1:0]  rsp_cause
);
  // Collides flag agrees with the cause
  a_collides_cause: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_collides == (rsp_cause != tmbc_pkg::CAUSE_NONE)))
    else $error("collides does not match cause");

  // Cause is always a defined code
  a_cause_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_cause == tmbc_pkg::CAUSE_NONE ||
                   rsp_cause == tmbc_pkg::CAUSE_OUTSIDE ||
                   rsp_cause == tmbc_pkg::CAUSE_SOLID))
    else $error("undefined cause code");

  // One query at a time: busy right after a query transaction
  a_busy_after_query: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_op == tmbc_pkg::OP_QUERY) |=> !req_ready)
    else $error("query accepted back to back");

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_cause)))
    else $error("stalled result changed");
endmodule

bind tile_map_box_collision tmbc_chk u_tmbc_chk (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_op       (req.op),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_collides (rsp.collides),
  .rsp_cause    (rsp.cause)
);
